// ----- rtl/tsped_pkg.sv -----
// ----------------------------------------------------------------------------
// tsped_pkg
// Shared types and constants for the two-switch press event decoder.
// ----------------------------------------------------------------------------
package tsped_pkg;

	localparam int unsigned TicksW = 8;
	localparam logic [TicksW-1:0] LongPressReset = 8'd10;
	localparam logic [TicksW-1:0] TicksMax = '1;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_PAGE_DOWN = 4'd1,
		EV_DEC_SPEED = 4'd2,
		EV_PAGE_UP   = 4'd3,
		EV_INC_SPEED = 4'd4,
		EV_NEXT      = 4'd5,
		EV_PREV      = 4'd6,
		EV_START     = 4'd7,
		EV_STOP      = 4'd8
	} event_t;

	typedef struct packed {
		logic one_down;
		logic two_down;
		logic clear_mode;
	} tick_t;

	typedef struct packed {
		event_t ev;
		logic   autoscroll;
	} result_t;

endpackage

// ----- rtl/tsped_core.sv -----
// ----------------------------------------------------------------------------
// tsped_core
// Switch state, press timers and event decision for one poll tick per cycle in which step is high.
// ----------------------------------------------------------------------------
module tsped_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  tsped_pkg::tick_t      tick,
	input  logic [7:0]            long_press_ticks,
	output tsped_pkg::result_t    result
);
	import tsped_pkg::*;

	logic              level_one_q, level_two_q;
	logic              timing_one_q, timing_two_q;
	logic [TicksW-1:0] held_one_q, held_two_q;
	logic              scroll_q;

	logic              level_one_d, level_two_d;
	logic              timing_one_d, timing_two_d;
	logic [TicksW-1:0] held_one_d, held_two_d;
	logic              scroll_d;
	event_t            ev_d;

	always_comb begin
		level_one_d  = tick.one_down;
		level_two_d  = tick.two_down;
		timing_one_d = timing_one_q;
		timing_two_d = timing_two_q;
		scroll_d     = tick.clear_mode ? 1'b0 : scroll_q;
		ev_d         = EV_NONE;

		held_one_d = held_one_q;
		if (timing_one_q && held_one_q != TicksMax) begin
			held_one_d = held_one_q + TicksW'(1);
		end
		held_two_d = held_two_q;
		if (timing_two_q && held_two_q != TicksMax) begin
			held_two_d = held_two_q + TicksW'(1);
		end

		if (tick.one_down != level_one_q) begin
			if (tick.one_down) begin
				timing_one_d = 1'b1;
				held_one_d   = '0;
			end else begin
				timing_one_d = 1'b0;
				if (held_one_d < long_press_ticks) begin
					ev_d = scroll_d ? EV_DEC_SPEED : EV_PAGE_DOWN;
				end
			end
		end

		if (tick.two_down != level_two_q) begin
			if (tick.two_down) begin
				timing_two_d = 1'b1;
				held_two_d   = '0;
			end else begin
				timing_two_d = 1'b0;
				if (held_two_d < long_press_ticks) begin
					ev_d = scroll_d ? EV_INC_SPEED : EV_PAGE_UP;
				end
			end
		end

		if (timing_one_d && held_one_d >= long_press_ticks && !tick.two_down) begin
			timing_one_d = 1'b0;
			if (!scroll_d) begin
				ev_d = EV_NEXT;
			end
		end

		if (timing_two_d && held_two_d >= long_press_ticks) begin
			timing_two_d = 1'b0;
			if (!tick.one_down) begin
				if (!scroll_d) begin
					ev_d = EV_PREV;
				end
			end else begin
				scroll_d = !scroll_d;
				ev_d     = scroll_d ? EV_START : EV_STOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_one_q  <= 1'b0;
			level_two_q  <= 1'b0;
			timing_one_q <= 1'b0;
			timing_two_q <= 1'b0;
			held_one_q   <= '0;
			held_two_q   <= '0;
			scroll_q     <= 1'b0;
		end else if (step) begin
			level_one_q  <= level_one_d;
			level_two_q  <= level_two_d;
			timing_one_q <= timing_one_d;
			timing_two_q <= timing_two_d;
			held_one_q   <= held_one_d;
			held_two_q   <= held_two_d;
			scroll_q     <= scroll_d;
		end
	end

	assign result.ev         = ev_d;
	assign result.autoscroll = scroll_d;

endmodule

// ----- rtl/two_switch_press_event_decoder_top.sv -----
// ----------------------------------------------------------------------------
// two_switch_press_event_decoder_top
// Decodes sampled foot switch levels into page, section and autoscroll events.
// ----------------------------------------------------------------------------
// Each input transaction is one poll tick with the levels of both switches and
// a clear-mode strobe. Each tick yields exactly one output transaction with an
// event code, which is EV_NONE when nothing happened, and the autoscroll mode
// after that tick.
// The tick is held in an input register, decoded combinationally against the
// switch state, and the result lands in an output register, where it is valid
// until the receiver takes it. One tick can be accepted every cycle while the
// receiver keeps up, since the decode in front of the output register is
// combinational.
// When the receiver stalls, the result stays in the output register and one
// more tick waits in the input register; after that in_ready drops until the
// receiver takes the result.
// Reset clears both switch levels, the press timers and autoscroll mode, and
// sets the long-press threshold to ten ticks. The user writes the threshold
// via cfg_we and cfg_wdata while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
module two_switch_press_event_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       switch_one_down,
	input  logic       switch_two_down,
	input  logic       clear_mode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_code,
	output logic       autoscroll_on
);
	import tsped_pkg::*;

	logic [TicksW-1:0] long_press_q;
	logic              valid_s1;
	tick_t             tick_s1;
	logic              res_valid_q;
	result_t           res_q;
	result_t           res_d;
	logic              advance;

	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LongPressReset;
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				long_press_q <= cfg_wdata;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.one_down   <= switch_one_down;
			tick_s1.two_down   <= switch_two_down;
			tick_s1.clear_mode <= clear_mode;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	tsped_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.tick             (tick_s1),
		.long_press_ticks (long_press_q),
		.result           (res_d)
	);

	assign out_valid     = res_valid_q;
	assign event_code    = res_q.ev;
	assign autoscroll_on = res_q.autoscroll;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the two-switch press event decoder.
// ----------------------------------------------------------------------------
// Poll ticks are driven through the input handshake, and every accepted tick
// is run through a cycle-free model of the decoder that keeps its own switch
// levels, press timers, autoscroll mode and threshold. The model's result is
// queued, and each output transaction is compared field by field with the
// oldest queued result. Directed tests cover short and long presses, mode
// toggling, clearing, threshold boundaries, counter saturation and one long
// receiver stall that backs up the input. Random press gestures then run at
// several thresholds, with random idle cycles on both sides in most runs.
// ----------------------------------------------------------------------------
module testbench;
	import tsped_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 4;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic       switch_one_down;
	logic       switch_two_down;
	logic       clear_mode;
	logic       out_valid;
	logic       out_ready;
	logic [3:0] event_code;
	logic       autoscroll_on;

	two_switch_press_event_decoder_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.switch_one_down(switch_one_down),
		.switch_two_down(switch_two_down),
		.clear_mode     (clear_mode),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_code     (event_code),
		.autoscroll_on  (autoscroll_on)
	);

	logic [TicksW-1:0] threshold_q = LongPressReset;
	logic              level_one_q = 1'b0;
	logic              level_two_q = 1'b0;
	logic              timing_one_q = 1'b0;
	logic              timing_two_q = 1'b0;
	logic [TicksW-1:0] held_one_q = '0;
	logic [TicksW-1:0] held_two_q = '0;
	logic              scroll_q = 1'b0;

	result_t pending_results[$];
	int      errors = 0;
	int      cycles = 0;
	bit      gaps_on = 1'b1;
	int      hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic result_t decode_tick(input tick_t t);
		result_t r;
		r.ev = EV_NONE;
		if (t.clear_mode)
			scroll_q = 1'b0;
		if (timing_one_q && held_one_q != TicksMax)
			held_one_q = held_one_q + TicksW'(1);
		if (timing_two_q && held_two_q != TicksMax)
			held_two_q = held_two_q + TicksW'(1);

		if (t.one_down != level_one_q) begin
			level_one_q = t.one_down;
			if (t.one_down) begin
				timing_one_q = 1'b1;
				held_one_q = '0;
			end else begin
				timing_one_q = 1'b0;
				if (held_one_q < threshold_q) begin
					if (scroll_q)
						r.ev = EV_DEC_SPEED;
					else
						r.ev = EV_PAGE_DOWN;
				end
			end
		end

		if (t.two_down != level_two_q) begin
			level_two_q = t.two_down;
			if (t.two_down) begin
				timing_two_q = 1'b1;
				held_two_q = '0;
			end else begin
				timing_two_q = 1'b0;
				if (held_two_q < threshold_q) begin
					if (scroll_q)
						r.ev = EV_INC_SPEED;
					else
						r.ev = EV_PAGE_UP;
				end
			end
		end

		if (timing_one_q && held_one_q >= threshold_q && !t.two_down) begin
			timing_one_q = 1'b0;
			if (!scroll_q)
				r.ev = EV_NEXT;
		end

		if (timing_two_q && held_two_q >= threshold_q) begin
			timing_two_q = 1'b0;
			if (!t.one_down) begin
				if (!scroll_q)
					r.ev = EV_PREV;
			end else begin
				scroll_q = !scroll_q;
				if (scroll_q)
					r.ev = EV_START;
				else
					r.ev = EV_STOP;
			end
		end

		r.autoscroll = scroll_q;
		return r;
	endfunction

	always @(posedge clk) begin
		tick_t   seen;
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen = {switch_one_down, switch_two_down, clear_mode};
				pending_results.push_back(decode_tick(seen));
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: event_code %0d autoscroll_on %0b",
						event_code, autoscroll_on);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (event_code !== want.ev) begin
						$error("event_code: expected %0d, actual %0d", want.ev, event_code);
						errors++;
					end
					if (autoscroll_on !== want.autoscroll) begin
						$error("autoscroll_on: expected %0b, actual %0b",
							want.autoscroll, autoscroll_on);
						errors++;
					end
				end
			end
		end
	end

	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				stall = hold_req;
				hold_req = 0;
			end else if (stall == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_tick(input logic one, input logic two, input logic clr);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		switch_one_down <= one;
		switch_two_down <= two;
		clear_mode <= clr;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	task automatic hold(input int one, input int two, input int clr, input int count);
		repeat (count) send_tick(1'(one), 1'(two), 1'(clr));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [7:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold_q = value;
	endtask

	function automatic int pick_span(input int thr);
		case ($urandom_range(0, 3))
			0: pick_span = $urandom_range(1, 3);
			1: pick_span = (thr > 1) ? $urandom_range(1, thr - 1) : 1;
			2: pick_span = thr - 1 + $urandom_range(0, 2);
			default: pick_span = thr + $urandom_range(1, 6);
		endcase
		if (pick_span < 1)
			pick_span = 1;
	endfunction

	// Short presses at the reset threshold, including both switches on one tick.
	task automatic test_short_presses();
		hold(1, 0, 0, 1);
		hold(0, 0, 0, 1);
		hold(0, 1, 0, 2);
		hold(0, 0, 0, 1);
		hold(1, 1, 0, 1);
		hold(0, 0, 0, 1);
	endtask

	task automatic test_long_presses();
		set_threshold(8'd2);
		hold(1, 0, 0, 4);
		hold(0, 0, 0, 1);
		hold(0, 1, 0, 4);
		hold(0, 0, 0, 1);
		// Released exactly at the threshold: neither short nor long.
		hold(1, 0, 0, 2);
		hold(0, 0, 0, 1);
		hold(1, 0, 0, 1);
		hold(1, 1, 0, 4);
		hold(0, 0, 0, 1);
		hold(1, 0, 0, 1);
		hold(0, 0, 0, 1);
		hold(0, 1, 0, 1);
		hold(0, 0, 0, 1);
		hold(1, 0, 0, 4);
		hold(0, 0, 0, 1);
		hold(1, 0, 0, 1);
		hold(1, 1, 0, 3);
		hold(0, 0, 0, 1);
		hold(1, 1, 0, 4);
		hold(0, 0, 1, 1);
		hold(0, 1, 1, 2);
		hold(0, 0, 0, 1);
	endtask

	task automatic test_threshold_extremes();
		set_threshold(8'd1);
		hold(0, 1, 0, 2);
		hold(0, 0, 0, 1);
		hold(1, 0, 0, 1);
		hold(0, 0, 0, 1);
		set_threshold(8'd255);
		hold(1, 0, 0, 100);
		hold(0, 0, 0, 1);
		// Both counters saturate while switch two blocks the long hold of switch one.
		hold(1, 1, 0, 300);
		hold(1, 0, 0, 2);
		hold(0, 0, 0, 2);
	endtask

	task automatic test_backpressure();
		bit saved;
		set_threshold(8'd3);
		saved = gaps_on;
		gaps_on = 1'b0;
		hold_req = 60;
		repeat (5) begin
			hold(1, 0, 0, 2);
			hold(0, 0, 0, 1);
			hold(0, 1, 0, 1);
		end
		gaps_on = saved;
		drain();
	endtask

	task automatic run_gestures(input logic [7:0] thr, input int count);
		logic one, two, clr;
		int left_one, left_two;
		set_threshold(thr);
		one = 1'b0;
		two = 1'b0;
		left_one = pick_span(int'(thr));
		left_two = pick_span(int'(thr));
		repeat (count) begin
			left_one--;
			if (left_one == 0) begin
				one = !one;
				left_one = pick_span(int'(thr));
			end
			left_two--;
			if (left_two == 0) begin
				two = !two;
				left_two = pick_span(int'(thr));
			end
			clr = ($urandom_range(0, 19) == 0);
			if ($urandom_range(0, 9) == 0)
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), clr);
			else
				send_tick(one, two, clr);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		switch_one_down = 1'b0;
		switch_two_down = 1'b0;
		clear_mode = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_presses();
		test_long_presses();
		test_threshold_extremes();
		test_backpressure();
		run_gestures(8'd10, 150);
		run_gestures(8'd1, 100);
		run_gestures(8'd3, 150);
		run_gestures(8'($urandom_range(2, 20)), 150);
		gaps_on = 1'b0;
		run_gestures(8'd6, 100);
		drain();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tsped_pkg.sv
rtl/tsped_core.sv
rtl/two_switch_press_event_decoder_top.sv
tb/sv/testbench.sv
